// ===== design/anisotropic_heat_flux_stencil_macros.svh =====
// Assertion macros shared by the stencil RTL.
// In synthesis builds the macros expand to nothing.
`ifndef ANISOTROPIC_HEAT_FLUX_STENCIL_MACROS_SVH
`define ANISOTROPIC_HEAT_FLUX_STENCIL_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge out of reset.
`define AHFS_ASSERT_ALWAYS(name, clk_sig, rst_sig, cond, msg) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (cond)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define AHFS_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons, msg) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AHFS_ASSERT_ALWAYS(name, clk_sig, rst_sig, cond, msg)
`define AHFS_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons, msg)
`endif
`endif

// ===== design/ahfs_pkg.sv =====
package ahfs_pkg;

    // Default build parameters.
    localparam int MAX_CELLS_X_DEF = 64;
    localparam int FRAC_BITS_DEF   = 16;

    // Register field widths and limits.
    localparam int CELLS_X_W = 7;
    localparam int ROW_W     = 13;
    localparam int CFG_IDX_W = 8;
    localparam logic [ROW_W-1:0] ROW_LIMIT = 13'd4096;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_X       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING_X = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING_Y = 8'd3;

    // Register reset values.
    localparam logic [CELLS_X_W-1:0] CELLS_X_RST = 7'd64;
    localparam logic [ROW_W-1:0]     CELLS_Y_RST = 13'd64;
    localparam logic [31:0]          INV_SPACING_RST = 32'd4194304;

    // Step strobes from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic take;
        logic load;
        logic mul_x;
        logic mul_y;
        logic sum_y;
        logic flux_0;
        logic flux_1;
        logic flux_2;
        logic flux_3;
    } ahfs_ctrl_t;

endpackage

// ===== design/ahfs_datapath.sv =====
module ahfs_datapath #(
    parameter int FRAC_BITS = ahfs_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ahfs_pkg::ahfs_ctrl_t ctrl,
    input  logic signed [31:0]  temperature,
    input  logic signed [31:0]  diff_xx,
    input  logic signed [31:0]  diff_xy,
    input  logic signed [31:0]  diff_yy,
    input  logic signed [31:0]  line_rd,
    input  logic [31:0]         inv_spacing_x,
    input  logic [31:0]         inv_spacing_y,
    output logic signed [31:0]  fx,
    output logic signed [31:0]  fy
);
    import ahfs_pkg::*;

    localparam int MAG_W  = 34;
    localparam int PP_W   = MAG_W + 16;
    localparam int FULL_W = PP_W + 17;
    localparam logic [63:0] TRUNC_BIAS = (64'd1 << FRAC_BITS) - 64'd1;

    // Scale a gradient partial product pair, truncate toward zero, saturate.
    function automatic logic signed [31:0] grad_fix(
        input logic [PP_W-1:0] hi_p,
        input logic [PP_W-1:0] lo_p,
        input logic            neg
    );
        logic [FULL_W-1:0] full;
        logic [FULL_W-1:0] q;
        logic signed [31:0] res;
        full = (FULL_W'(hi_p) << 16) + FULL_W'(lo_p);
        q = full >> (FRAC_BITS + 1);
        if (neg) begin
            if (q[FULL_W-1:32] != '0 || (q[31] && q[30:0] != '0)) begin
                res = 32'sh8000_0000;
            end
            else begin
                res = $signed(~q[31:0] + 32'd1);
            end
        end
        else begin
            if (q[FULL_W-1:31] != '0) begin
                res = 32'sh7FFF_FFFF;
            end
            else begin
                res = $signed(q[31:0]);
            end
        end
        return res;
    endfunction

    // Truncate two products toward zero, add them and saturate.
    function automatic logic signed [31:0] flux_sum(
        input logic signed [63:0] pa,
        input logic signed [63:0] pb
    );
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        logic signed [64:0] s;
        logic signed [31:0] res;
        sa = (pa + (pa[63] ? $signed(TRUNC_BIAS) : 64'sd0)) >>> FRAC_BITS;
        sb = (pb + (pb[63] ? $signed(TRUNC_BIAS) : 64'sd0)) >>> FRAC_BITS;
        s = {sa[63], sa} + {sb[63], sb};
        if (s[64:31] == '0 || s[64:31] == '1) begin
            res = s[31:0];
        end
        else if (s[64]) begin
            res = 32'sh8000_0000;
        end
        else begin
            res = 32'sh7FFF_FFFF;
        end
        return res;
    endfunction

    logic signed [31:0] tr_reg;
    logic signed [31:0] dxx_reg;
    logic signed [31:0] dxy_reg;
    logic signed [31:0] dyy_reg;
    logic signed [31:0] prev_cur_reg;
    logic signed [31:0] prev_prev_reg;
    logic [MAG_W-1:0]   mag_x_reg;
    logic [MAG_W-1:0]   mag_y_reg;
    logic               neg_x_reg;
    logic               neg_y_reg;
    logic [PP_W-1:0]    gp_hi_reg;
    logic [PP_W-1:0]    gp_lo_reg;
    logic signed [31:0] gx_reg;
    logic signed [31:0] gy_reg;
    logic signed [63:0] fp_a_reg;
    logic signed [63:0] fp_b_reg;
    logic signed [31:0] fx_reg;

    logic signed [MAG_W-1:0] e_tr;
    logic signed [MAG_W-1:0] e_r;
    logic signed [MAG_W-1:0] e_t;
    logic signed [MAG_W-1:0] e_i;
    logic signed [MAG_W-1:0] dx;
    logic signed [MAG_W-1:0] dy;
    logic [MAG_W-1:0]        g_mag;
    logic [31:0]             g_inv;
    logic signed [31:0]      op_a;
    logic signed [31:0]      op_b;
    logic signed [63:0]      prod;

    // Corner differences of the 2x2 window.
    always_comb
    begin
        e_tr = MAG_W'(tr_reg);
        e_r  = MAG_W'(line_rd);
        e_t  = MAG_W'(prev_cur_reg);
        e_i  = MAG_W'(prev_prev_reg);
        dx   = (e_tr + e_r) - (e_t + e_i);
        dy   = (e_tr + e_t) - (e_r + e_i);
    end

    // Operand selection for the split gradient multipliers.
    assign g_mag = ctrl.mul_x ? mag_x_reg : mag_y_reg;
    assign g_inv = ctrl.mul_x ? inv_spacing_x : inv_spacing_y;

    // Operand selection for the shared flux multiplier.
    assign op_a = ctrl.flux_0 ? dxx_reg : ((ctrl.flux_1 || ctrl.flux_2) ? dxy_reg : dyy_reg);
    assign op_b = (ctrl.flux_0 || ctrl.flux_2) ? gx_reg : gy_reg;
    assign prod = 64'(op_a) * 64'(op_b);

    // Window registers, reset to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_cur_reg  <= '0;
            prev_prev_reg <= '0;
        end
        else if (ctrl.load)
        begin
            prev_cur_reg  <= tr_reg;
            prev_prev_reg <= line_rd;
        end
    end

    // Arithmetic steps of one item.
    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            tr_reg  <= temperature;
            dxx_reg <= diff_xx;
            dxy_reg <= diff_xy;
            dyy_reg <= diff_yy;
        end
        if (ctrl.load)
        begin
            neg_x_reg <= dx[MAG_W-1];
            neg_y_reg <= dy[MAG_W-1];
            mag_x_reg <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
            mag_y_reg <= dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
        end
        if (ctrl.mul_x || ctrl.mul_y)
        begin
            gp_hi_reg <= PP_W'(g_mag) * PP_W'(g_inv[31:16]);
            gp_lo_reg <= PP_W'(g_mag) * PP_W'(g_inv[15:0]);
        end
        if (ctrl.mul_y)
        begin
            gx_reg <= grad_fix(gp_hi_reg, gp_lo_reg, neg_x_reg);
        end
        if (ctrl.sum_y)
        begin
            gy_reg <= grad_fix(gp_hi_reg, gp_lo_reg, neg_y_reg);
        end
        if (ctrl.flux_0 || ctrl.flux_2)
        begin
            fp_a_reg <= prod;
        end
        if (ctrl.flux_1 || ctrl.flux_3)
        begin
            fp_b_reg <= prod;
        end
        if (ctrl.flux_2)
        begin
            fx_reg <= flux_sum(fp_a_reg, fp_b_reg);
        end
    end

    assign fx = fx_reg;
    assign fy = flux_sum(fp_a_reg, fp_b_reg);

endmodule

// ===== design/anisotropic_heat_flux_stencil.sv =====
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   temperature, diff_xx, diff_xy, diff_yy
// out       output     out_valid / out_stall flux_x, flux_y, cell_col, cell_row, last_cell
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// An item that yields a flux holds the block through these steps after acceptance:
// window load, two split gradient multiply steps, the second gradient scaling, four
// steps on the shared 32x32 flux multiplier, and the output step. A border node holds
// the block only for the window load step.
// Reset clears the counters, window and settings; the line buffer needs no clearing.
// A result waiting in a stalled output register blocks only the output step.
`include "anisotropic_heat_flux_stencil_macros.svh"

module anisotropic_heat_flux_stencil #(
    parameter int MAX_CELLS_X = ahfs_pkg::MAX_CELLS_X_DEF,
    parameter int FRAC_BITS   = ahfs_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [31:0]             temperature,
    input  logic signed [31:0]             diff_xx,
    input  logic signed [31:0]             diff_xy,
    input  logic signed [31:0]             diff_yy,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [31:0]             flux_x,
    output logic signed [31:0]             flux_y,
    output logic [5:0]                     cell_col,
    output logic [11:0]                    cell_row,
    output logic                           last_cell,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ahfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);
    import ahfs_pkg::*;

    localparam int COL_W    = $clog2(MAX_CELLS_X + 1);
    localparam int LB_DEPTH = MAX_CELLS_X + 1;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_LOAD   = 10'b00_0000_0010,
        S_MUL_X  = 10'b00_0000_0100,
        S_MUL_Y  = 10'b00_0000_1000,
        S_SUM_Y  = 10'b00_0001_0000,
        S_FLUX_0 = 10'b00_0010_0000,
        S_FLUX_1 = 10'b00_0100_0000,
        S_FLUX_2 = 10'b00_1000_0000,
        S_FLUX_3 = 10'b01_0000_0000,
        S_FLUX_4 = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [CELLS_X_W-1:0] cells_x_reg;
    logic [ROW_W-1:0]     cells_y_reg;
    logic [31:0]          inv_x_reg;
    logic [31:0]          inv_y_reg;

    logic [COL_W-1:0] node_col_reg;
    logic [ROW_W-1:0] node_row_reg;
    logic             has_res_reg;
    logic [5:0]       col_hold_reg;
    logic [11:0]      row_hold_reg;
    logic             last_hold_reg;

    logic [31:0] line_mem [LB_DEPTH];
    logic [31:0] line_rd_reg;

    logic               out_valid_reg;
    logic signed [31:0] flux_x_reg;
    logic signed [31:0] flux_y_reg;
    logic [5:0]         cell_col_reg;
    logic [11:0]        cell_row_reg;
    logic               last_cell_reg;

    logic [COL_W-1:0]   ncx;
    logic [ROW_W-1:0]   ncy;
    logic               in_acc;
    logic               out_free;
    logic               col_end;
    logic               row_end;
    ahfs_ctrl_t         ctrl;
    logic signed [31:0] fx;
    logic signed [31:0] fy;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // Effective grid size, clamped to the supported range.
    always_comb
    begin
        if (cells_x_reg == '0)
        begin
            ncx = COL_W'(1);
        end
        else if (32'(cells_x_reg) > 32'(MAX_CELLS_X))
        begin
            ncx = COL_W'(MAX_CELLS_X);
        end
        else
        begin
            ncx = COL_W'(cells_x_reg);
        end
        if (cells_y_reg == '0)
        begin
            ncy = ROW_W'(1);
        end
        else if (cells_y_reg > ROW_LIMIT)
        begin
            ncy = ROW_LIMIT;
        end
        else
        begin
            ncy = cells_y_reg;
        end
    end

    assign col_end = (node_col_reg >= ncx);
    assign row_end = (node_row_reg >= ncy);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_x_reg <= CELLS_X_RST;
            cells_y_reg <= CELLS_Y_RST;
            inv_x_reg   <= INV_SPACING_RST;
            inv_y_reg   <= INV_SPACING_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CELLS_X:       cells_x_reg <= cfg_data[CELLS_X_W-1:0];
                REG_CELLS_Y:       cells_y_reg <= cfg_data[ROW_W-1:0];
                REG_INV_SPACING_X: inv_x_reg   <= cfg_data;
                REG_INV_SPACING_Y: inv_y_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Node position in the raster scan.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_col_reg <= '0;
            node_row_reg <= '0;
            has_res_reg  <= 1'b0;
        end
        else if (in_acc)
        begin
            has_res_reg <= (node_col_reg != '0) && (node_row_reg != '0);
            if (col_end)
            begin
                node_col_reg <= '0;
                node_row_reg <= row_end ? '0 : node_row_reg + ROW_W'(1);
            end
            else
            begin
                node_col_reg <= node_col_reg + COL_W'(1);
            end
        end
    end

    // Cell tag of the accepted item.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            col_hold_reg  <= 6'(node_col_reg - COL_W'(1));
            row_hold_reg  <= 12'(node_row_reg - ROW_W'(1));
            last_hold_reg <= col_end && row_end;
        end
    end

    // Line buffer: read-first, so the old row value and the new one share one access.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            line_rd_reg            <= line_mem[node_col_reg];
            line_mem[node_col_reg] <= temperature;
        end
    end

    // Step sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   state_next = in_acc ? S_LOAD : S_IDLE;
            S_LOAD:   state_next = has_res_reg ? S_MUL_X : S_IDLE;
            S_MUL_X:  state_next = S_MUL_Y;
            S_MUL_Y:  state_next = S_SUM_Y;
            S_SUM_Y:  state_next = S_FLUX_0;
            S_FLUX_0: state_next = S_FLUX_1;
            S_FLUX_1: state_next = S_FLUX_2;
            S_FLUX_2: state_next = S_FLUX_3;
            S_FLUX_3: state_next = S_FLUX_4;
            S_FLUX_4: state_next = out_free ? S_IDLE : S_FLUX_4;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctrl.take   = in_acc;
        ctrl.load   = (state_reg == S_LOAD);
        ctrl.mul_x  = (state_reg == S_MUL_X);
        ctrl.mul_y  = (state_reg == S_MUL_Y);
        ctrl.sum_y  = (state_reg == S_SUM_Y);
        ctrl.flux_0 = (state_reg == S_FLUX_0);
        ctrl.flux_1 = (state_reg == S_FLUX_1);
        ctrl.flux_2 = (state_reg == S_FLUX_2);
        ctrl.flux_3 = (state_reg == S_FLUX_3);
    end

    ahfs_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .temperature   (temperature),
        .diff_xx       (diff_xx),
        .diff_xy       (diff_xy),
        .diff_yy       (diff_yy),
        .line_rd       (line_rd_reg),
        .inv_spacing_x (inv_x_reg),
        .inv_spacing_y (inv_y_reg),
        .fx            (fx),
        .fy            (fy)
    );

    // Output register: holds one result item until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_FLUX_4 && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FLUX_4 && out_free)
        begin
            flux_x_reg    <= fx;
            flux_y_reg    <= fy;
            cell_col_reg  <= col_hold_reg;
            cell_row_reg  <= row_hold_reg;
            last_cell_reg <= last_hold_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign flux_x    = flux_x_reg;
    assign flux_y    = flux_y_reg;
    assign cell_col  = cell_col_reg;
    assign cell_row  = cell_row_reg;
    assign last_cell = last_cell_reg;

    // Checks on the scan counters and the sequencer.
    `AHFS_ASSERT_ALWAYS(a_col_range, clk, rst_n, node_col_reg <= COL_W'(MAX_CELLS_X), "column counter beyond line buffer")
    `AHFS_ASSERT_ALWAYS(a_row_range, clk, rst_n, node_row_reg <= ROW_LIMIT, "row counter beyond grid limit")
    `AHFS_ASSERT_NEXT(a_take_load, clk, rst_n, in_acc, state_reg == S_LOAD, "accepted item did not reach the load step")
    `AHFS_ASSERT_NEXT(a_hold_result, clk, rst_n, state_reg == S_FLUX_4 && out_valid_reg && out_stall, state_reg == S_FLUX_4, "finished result left while output was full")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import ahfs_pkg::*;

    localparam int MAX_X = MAX_CELLS_X_DEF;
    localparam int FRAC = FRAC_BITS_DEF;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    // An index that maps to no register; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'hFF;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int SETTLE_CYCLES = 12;

    // Idle and stall percentages for the four traffic modes.
    localparam int SEND_IDLE [4] = '{0, 57, 0, 22};
    localparam int RECV_STALL [4] = '{0, 0, 57, 22};

    typedef struct {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic [5:0] col;
        logic [11:0] row;
        logic last;
    } flux_cell_t;

    // Tracks the corner window and registers, and holds the fluxes still due.
    class cell_flux_tracker;
        bit [6:0] cells_x;
        bit [12:0] cells_y;
        bit [31:0] inv_x;
        bit [31:0] inv_y;
        longint line_temp [0:MAX_X];
        bit line_set [0:MAX_X];
        longint left_temp;
        longint left_below_temp;
        int unsigned node_col;
        int unsigned node_row;
        flux_cell_t flux_due [$];
        int mismatches;

        function new();
            cells_x = CELLS_X_RST;
            cells_y = CELLS_Y_RST;
            inv_x = INV_SPACING_RST;
            inv_y = INV_SPACING_RST;
            foreach (line_set[i]) line_set[i] = 1'b0;
            foreach (line_temp[i]) line_temp[i] = 0;
            left_temp = 0;
            left_below_temp = 0;
            node_col = 0;
            node_row = 0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] data);
            case (idx)
                REG_CELLS_X: cells_x = data[6:0];
                REG_CELLS_Y: cells_y = data[12:0];
                REG_INV_SPACING_X: inv_x = data;
                REG_INV_SPACING_Y: inv_y = data;
                default: ;
            endcase
        endfunction

        // Past the first row, a wider grid must only reach line entries already filled.
        function bit [6:0] safe_cells_x(bit [6:0] want);
            int top;
            int lim;
            top = (want < 1) ? 1 : ((want > MAX_X) ? MAX_X : want);
            if (node_row == 0) return want;
            lim = 0;
            while (lim < MAX_X && line_set[lim + 1]) lim++;
            return (top > lim) ? 7'(lim) : want;
        endfunction

        // Gradient: truncate |d| * inv / 2^(FRAC+1) toward zero and saturate.
        function longint slope(longint d, bit [31:0] inv);
            bit [127:0] mag;
            bit [127:0] q;
            mag = (d < 0) ? 128'(-d) : 128'(d);
            q = (mag * {96'd0, inv}) >> (FRAC + 1);
            if (d < 0) return (q > 128'h8000_0000) ? S32_MIN : -longint'(q[63:0]);
            return (q > 128'h7FFF_FFFF) ? S32_MAX : longint'(q[63:0]);
        endfunction

        // Tensor times gradient, truncated toward zero to FRAC fraction bits.
        function longint fix_mul(longint c, longint g);
            longint p;
            longint m;
            p = c * g;
            m = (p < 0) ? -p : p;
            m = m >> FRAC;
            return (p < 0) ? -m : m;
        endfunction

        function logic signed [31:0] clip32(longint v);
            if (v > S32_MAX) return 32'sh7FFF_FFFF;
            if (v < S32_MIN) return 32'sh8000_0000;
            return v[31:0];
        endfunction

        function int pending();
            return flux_due.size();
        endfunction

        // Advance the window by one accepted node and queue the cell flux it closes.
        function void take_node(bit [31:0] temp, bit [31:0] xx, bit [31:0] xy, bit [31:0] yy);
            int unsigned ncx;
            int unsigned ncy;
            int unsigned col;
            int unsigned row;
            longint t_tr;
            longint t_r;
            longint t_i;
            longint t_t;
            longint gx;
            longint gy;
            flux_cell_t due;
            ncx = (cells_x < 1) ? 1 : ((cells_x > MAX_X) ? MAX_X : cells_x);
            ncy = (cells_y < 1) ? 1 : ((cells_y > ROW_LIMIT) ? ROW_LIMIT : cells_y);
            col = (node_col > MAX_X) ? MAX_X : node_col;
            row = node_row;
            t_tr = longint'($signed(temp));
            t_r = line_temp[col];
            t_i = left_below_temp;
            t_t = left_temp;

            if (col > 0 && row > 0) begin
                gx = slope((t_tr + t_r) - (t_t + t_i), inv_x);
                gy = slope((t_tr + t_t) - (t_r + t_i), inv_y);
                due.fx = clip32(fix_mul(longint'($signed(xx)), gx)
                                + fix_mul(longint'($signed(xy)), gy));
                due.fy = clip32(fix_mul(longint'($signed(xy)), gx)
                                + fix_mul(longint'($signed(yy)), gy));
                due.col = 6'(col - 1);
                due.row = 12'(row - 1);
                due.last = (col >= ncx && row >= ncy);
                flux_due.push_back(due);
            end

            left_below_temp = t_r;
            line_temp[col] = t_tr;
            line_set[col] = 1'b1;
            left_temp = t_tr;

            // Column wrap moves to the next row; the last row wraps to the frame start.
            if (col >= ncx) begin
                node_col = 0;
                node_row = (row >= ncy) ? 0 : row + 1;
            end else begin
                node_col = col + 1;
                node_row = row;
            end
        endfunction

        function void compare_field(string name, logic signed [63:0] want,
                                    logic signed [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void match_flux(logic signed [31:0] fx, logic signed [31:0] fy,
                                 logic [5:0] col, logic [11:0] row, logic last);
            flux_cell_t want;
            if (flux_due.size() == 0) begin
                $display("%0t: flux item for cell (%0d,%0d) arrived with none predicted",
                         $time, col, row);
                mismatches++;
                return;
            end
            want = flux_due.pop_front();
            compare_field("flux_x", want.fx, fx);
            compare_field("flux_y", want.fy, fy);
            compare_field("cell_col", want.col, col);
            compare_field("cell_row", want.row, row);
            compare_field("last_cell", want.last, last);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] temperature = '0;
    logic signed [31:0] diff_xx = '0;
    logic signed [31:0] diff_xy = '0;
    logic signed [31:0] diff_yy = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] flux_x;
    logic signed [31:0] flux_y;
    logic [5:0] cell_col;
    logic [11:0] cell_row;
    logic last_cell;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int send_pct = 0;
    int stall_pct = 0;
    cell_flux_tracker flux_book;

    anisotropic_heat_flux_stencil i_dut (.*);

    always #6 clk = ~clk;

    // Result side: check each accepted item, then pick the next stall.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            flux_book.match_flux(flux_x, flux_y, cell_col, cell_row, last_cell);
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Q16.16 values: mostly moderate magnitudes, with extremes mixed in.
    function automatic bit [31:0] pick_q16(int span);
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4: return $urandom;
            default: return $urandom_range(2 << span) - (1 << span);
        endcase
    endfunction

    function automatic bit [31:0] pick_spacing();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(32'h0040_0000, 32'h0001_0000);
            2: return 32'h0001_0000;
            default: return $urandom_range(32'hFFFF);
        endcase
    endfunction

    task automatic push_node(bit [31:0] t, bit [31:0] xx, bit [31:0] xy, bit [31:0] yy);
        if (send_pct != 0 && $urandom_range(99) < send_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_pct);
        end
        in_valid <= 1'b1;
        temperature <= t;
        diff_xx <= xx;
        diff_xy <= xy;
        diff_yy <= yy;
        do @(posedge clk); while (in_stall);
        flux_book.take_node(t, xx, xy, yy);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        flux_book.set_reg(idx, data);
    endtask

    // Writes all four registers; unused upper bits of the size registers are random.
    task automatic set_grid(bit [6:0] cx, bit [12:0] cy, bit [31:0] ix, bit [31:0] iy);
        bit [6:0] cx_ok;
        cx_ok = flux_book.safe_cells_x(cx);
        write_reg(REG_CELLS_X, ($urandom & 32'hFFFF_FF80) | 32'(cx_ok));
        write_reg(REG_CELLS_Y, ($urandom & 32'hFFFF_E000) | 32'(cy));
        write_reg(REG_INV_SPACING_X, ix);
        write_reg(REG_INV_SPACING_Y, iy);
        cfg_valid <= 1'b0;
    endtask

    // Drain every predicted flux, then let a border node still in flight finish.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (flux_book.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int k;
        int n;
        bit [6:0] cx;
        bit [12:0] cy;
        flux_book = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A 2x2 cell grid with saturating corners, extreme tensors and small
        // negative differences that exercise truncation toward zero.
        set_grid(7'd2, 13'd2, 32'hFFFF_FFFF, 32'h0001_0000);
        push_node(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        push_node(32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
        push_node(32'h8000_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0002_0000);
        push_node(32'h8000_0000, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F);
        push_node(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_node(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        push_node(32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
        push_node(32'h0000_0003, 32'hFFFF_8000, 32'h0000_0001, 32'hFFFF_FFFF);
        push_node(32'hFFFF_FFFD, 32'h0001_8000, 32'hFFFF_FFFF, 32'h0000_0001);
        settle();

        // Sizes below range clamp to a single cell; the spare index is ignored.
        write_reg(REG_SPARE, 32'h5A5A_A5A5);
        set_grid(7'd0, 13'd0, 32'h0000_0000, 32'hFFFF_FFFF);
        for (n = 0; n < 8; n++)
            push_node(pick_q16(20), pick_q16(18), pick_q16(18), pick_q16(18));
        settle();

        // Random traffic over several grid settings, changed without regard to
        // the frame position so that mid-frame wraps occur.
        for (k = 0; k < 8; k++) begin
            send_pct = SEND_IDLE[k % 4];
            stall_pct = RECV_STALL[k % 4];
            case (k)
                0: begin cx = 7'd64; cy = 13'd4096; end
                3: begin cx = 7'd1; cy = 13'd1; end
                6: begin cx = 7'd127; cy = 13'd8191; end
                default: begin cx = 7'($urandom_range(6, 1)); cy = 13'($urandom_range(5, 1)); end
            endcase
            if (k == 2) cy = 13'd0;
            if (k == 1) set_grid(cx, cy, 32'hFFFF_FFFF, 32'h0000_0000);
            else set_grid(cx, cy, pick_spacing(), pick_spacing());
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Once, hold the stream until every outstanding flux has drained.
                if (k == 5 && n == ITEMS_PER_PHASE / 2) begin
                    in_valid <= 1'b0;
                    do @(posedge clk); while (flux_book.pending() != 0);
                end
                push_node(pick_q16(20), pick_q16(18), pick_q16(18), pick_q16(18));
            end
            settle();
        end

        if (flux_book.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
